[rtl/spwq_pkg.sv]
// spwq_pkg: shared types and constants for the stable priority work queue
// no dependencies

package spwq_pkg;

   localparam int QueueDepthDefault = 16;
   localparam int PrioWidth = 8;
   localparam int TagWidth = 32;
   localparam int OccWidth = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TAKE   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_PLACE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [TagWidth-1:0] taken_job;
      logic                job_valid;
      logic                now_empty;
      logic                insert_refused;
      logic [OccWidth-1:0] occupancy;
   } rsp_type;

endpackage

[rtl/spwq_if.sv]
// spwq_req_if / spwq_rsp_if: valid/ready channels of the queue
// depends on spwq_pkg

interface spwq_req_if;
   logic                           valid;
   logic                           ready;
   spwq_pkg::op_type               operation;
   logic [spwq_pkg::PrioWidth-1:0] job_priority;
   logic [spwq_pkg::TagWidth-1:0]  job_tag;
   modport source (output valid, operation, job_priority, job_tag, input ready);
   modport sink (input valid, operation, job_priority, job_tag, output ready);
endinterface

interface spwq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spwq_pkg::TagWidth-1:0] taken_job;
   logic                          job_valid;
   logic                          now_empty;
   logic                          insert_refused;
   logic [spwq_pkg::OccWidth-1:0] occupancy;
   modport source (output valid, taken_job, job_valid, now_empty, insert_refused,
                   occupancy, input ready);
   modport sink (input valid, taken_job, job_valid, now_empty, insert_refused,
                 occupancy, output ready);
endinterface

[rtl/spwq_mem.sv]
// spwq_mem: slot store, priority and tag per entry, one write and one read port
// depends on spwq_pkg

module spwq_mem #(
   parameter int QueueDepth = spwq_pkg::QueueDepthDefault,
   localparam int AddrWidth = $clog2(QueueDepth)
) (
   input  logic                                              clock,
   input  logic                                              wr_en,
   input  logic [AddrWidth-1:0]                              wr_addr,
   input  logic [spwq_pkg::PrioWidth+spwq_pkg::TagWidth-1:0] wr_data,
   input  logic [AddrWidth-1:0]                              rd_addr,
   output logic [spwq_pkg::PrioWidth+spwq_pkg::TagWidth-1:0] rd_data
);

   logic [spwq_pkg::PrioWidth+spwq_pkg::TagWidth-1:0] mem [QueueDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/stable_priority_work_queue.sv]
// stable_priority_work_queue: top level, sequencer around the slot store
// depends on spwq_pkg, spwq_if, spwq_mem
//
// Usage:
//   req channel carries one beat per operation: insert (priority, tag) or take.
//   rsp channel returns exactly one beat per request, in order.
//   Entries are kept sorted in a memory with one read and one write port,
//   slot 0 the head; equal priorities keep arrival order.
//   An insert reads from the tail toward the head, moving each entry with a
//   higher number up one slot per cycle, then writes the new job; into an
//   empty queue it writes the new job directly. A take reads slot 0, then
//   moves every other entry down one slot per cycle. A refused insert or an
//   empty take goes straight to the response. The memory read port is
//   registered.
//   One request is in work at a time; req_ready is low until its response
//   beat has left the output register.
//   Reset (synchronous) empties the queue; memory contents are not cleared.
//   A stalled receiver holds the response and blocks the next request.

module stable_priority_work_queue #(
   parameter int QueueDepth = spwq_pkg::QueueDepthDefault
) (
   input logic       clock,
   input logic       reset,
   spwq_req_if.sink  req,
   spwq_rsp_if.source rsp
);

   localparam int AddrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);
   localparam int DataWidth = spwq_pkg::PrioWidth + spwq_pkg::TagWidth;

   spwq_pkg::state_type state_ff, state_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [CntWidth-1:0] idx_ff, idx_in;
   spwq_pkg::op_type op_ff, op_in;
   logic [spwq_pkg::PrioWidth-1:0] prio_ff, prio_in;
   logic [spwq_pkg::TagWidth-1:0] tag_ff, tag_in;
   spwq_pkg::rsp_type rsp_ff, rsp_in;

   logic wr_en;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   logic [DataWidth-1:0] wr_data, rd_data;
   logic [spwq_pkg::PrioWidth-1:0] rd_prio;

   spwq_mem #(.QueueDepth(QueueDepth)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_prio = rd_data[DataWidth-1 -: spwq_pkg::PrioWidth];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spwq_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      op_ff <= op_in;
      prio_ff <= prio_in;
      tag_ff <= tag_in;
      rsp_ff <= rsp_in;
   end

   function automatic spwq_pkg::rsp_type mk_rsp(logic [spwq_pkg::TagWidth-1:0] tag,
                                                 logic valid, logic refused,
                                                 logic [CntWidth-1:0] cnt);
      spwq_pkg::rsp_type r;
      r.taken_job = tag;
      r.job_valid = valid;
      r.now_empty = (cnt == '0);
      r.insert_refused = refused;
      r.occupancy = spwq_pkg::OccWidth'(cnt);
      return r;
   endfunction

   // idx_ff: slot whose read data arrives this cycle in ST_SHIFT, write slot in ST_PLACE
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      op_in = op_ff;
      prio_in = prio_ff;
      tag_in = tag_ff;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff[AddrWidth-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[AddrWidth-1:0];
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         spwq_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            rd_addr = '0;
            if (req.valid) begin
               op_in = req.operation;
               prio_in = req.job_priority;
               tag_in = req.job_tag;
               idx_in = '0;
               if (req.operation == spwq_pkg::OP_INSERT) begin
                  if (count_ff == CntWidth'(QueueDepth)) begin
                     rsp_in = mk_rsp('0, 1'b0, 1'b1, count_ff);
                     state_in = spwq_pkg::ST_OUT;
                  end else if (count_ff == '0) begin
                     state_in = spwq_pkg::ST_PLACE;
                  end else begin
                     // tail slot read now, scan walks toward the head
                     idx_in = count_ff - CntWidth'(1);
                     rd_addr = AddrWidth'(count_ff - CntWidth'(1));
                     state_in = spwq_pkg::ST_SHIFT;
                  end
               end else if (count_ff == '0) begin
                  rsp_in = mk_rsp('0, 1'b0, 1'b0, count_ff);
                  state_in = spwq_pkg::ST_OUT;
               end else begin
                  // slot 0 read is in flight
                  idx_in = CntWidth'(1);
                  state_in = spwq_pkg::ST_SEARCH;
               end
            end
         end
         spwq_pkg::ST_SEARCH: begin
            // rd_data holds the head slot
            tag_in = rd_data[spwq_pkg::TagWidth-1:0];
            if (count_ff == CntWidth'(1)) begin
               count_in = '0;
               rsp_in = mk_rsp(rd_data[spwq_pkg::TagWidth-1:0], 1'b1, 1'b0, '0);
               state_in = spwq_pkg::ST_OUT;
            end else begin
               rd_addr = idx_ff[AddrWidth-1:0];
               state_in = spwq_pkg::ST_SHIFT;
            end
         end
         spwq_pkg::ST_SHIFT: begin
            if (op_ff == spwq_pkg::OP_TAKE) begin
               // rd_data = slot idx_ff, write to idx_ff-1
               wr_en = 1'b1;
               wr_addr = AddrWidth'(idx_ff - CntWidth'(1));
               if (idx_ff + CntWidth'(1) == count_ff) begin
                  count_in = count_ff - CntWidth'(1);
                  rsp_in = mk_rsp(tag_ff, 1'b1, 1'b0, count_ff - CntWidth'(1));
                  state_in = spwq_pkg::ST_OUT;
               end else begin
                  idx_in = idx_ff + CntWidth'(1);
                  rd_addr = AddrWidth'(idx_ff + CntWidth'(1));
               end
            end else if (rd_prio > prio_ff) begin
               // higher number moves up one slot
               wr_en = 1'b1;
               wr_addr = AddrWidth'(idx_ff + CntWidth'(1));
               if (idx_ff == '0) begin
                  state_in = spwq_pkg::ST_PLACE;
               end else begin
                  idx_in = idx_ff - CntWidth'(1);
                  rd_addr = AddrWidth'(idx_ff - CntWidth'(1));
               end
            end else begin
               // equal or lower number stays ahead of the new job
               idx_in = idx_ff + CntWidth'(1);
               state_in = spwq_pkg::ST_PLACE;
            end
         end
         spwq_pkg::ST_PLACE: begin
            wr_en = 1'b1;
            wr_addr = idx_ff[AddrWidth-1:0];
            wr_data = {prio_ff, tag_ff};
            count_in = count_ff + CntWidth'(1);
            rsp_in = mk_rsp('0, 1'b0, 1'b0, count_ff + CntWidth'(1));
            state_in = spwq_pkg::ST_OUT;
         end
         spwq_pkg::ST_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = spwq_pkg::ST_IDLE;
            end
         end
         default: state_in = spwq_pkg::ST_IDLE;
      endcase
   end

   assign rsp.taken_job = rsp_ff.taken_job;
   assign rsp.job_valid = rsp_ff.job_valid;
   assign rsp.now_empty = rsp_ff.now_empty;
   assign rsp.insert_refused = rsp_ff.insert_refused;
   assign rsp.occupancy = rsp_ff.occupancy;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(QueueDepth))
      else $error("count above depth");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("accept while response pending");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != spwq_pkg::ST_OUT |=> $stable(count_ff) || state_ff == spwq_pkg::ST_OUT)
      else $error("count changed outside completion");
   a_refuse_full: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.insert_refused |-> count_ff == CntWidth'(QueueDepth))
      else $error("refusal with room left");

endmodule
